// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue: entry layout,
// ring index widths, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int CAPACITY    = 64;
   localparam int VALUE_W     = 32;
   localparam int COUNT_OUT_W = 7;
   localparam int STATUS_W    = 2;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // ring arithmetic constants
   localparam logic [IDX_W:0]   CAP_EXT  = (IDX_W + 1)'(CAPACITY);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNDERFLOW = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] item;
      logic signed [VALUE_W-1:0] prio;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic signed [VALUE_W-1:0] removed_item;
      logic signed [VALUE_W-1:0] removed_priority;
      logic signed [VALUE_W-1:0] head_item;
      status_type                status;
      logic [COUNT_OUT_W-1:0]    entry_count;
   } result_type;

   // memory access issued by the sequencer
   typedef struct packed {
      logic                 wr_en;
      logic                 rd_en;
      logic [IDX_W-1:0]     addr;
      entry_type            wr_data;
   } mem_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_REM_RD,
      ST_REM_CAP,
      ST_HEAD_RD,
      ST_HEAD_CAP
   } state_type;

endpackage

// ===== rtl/core/spq_if.sv =====
// ----------------------------------------------------------------------------
// spq channel interfaces
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------
interface spq_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 mode;
   logic signed [spq_pkg::VALUE_W-1:0]   item_value;
   logic signed [spq_pkg::VALUE_W-1:0]   item_priority;

   modport source (output valid, mode, item_value, item_priority, input ready);
   modport sink   (input valid, mode, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [spq_pkg::VALUE_W-1:0]   removed_item;
   logic signed [spq_pkg::VALUE_W-1:0]   removed_priority;
   logic signed [spq_pkg::VALUE_W-1:0]   head_item;
   logic [spq_pkg::STATUS_W-1:0]         status;
   logic [spq_pkg::COUNT_OUT_W-1:0]      entry_count;

   modport source (output valid, removed_item, removed_priority, head_item, status,
                   entry_count, input ready);
   modport sink   (input valid, removed_item, removed_priority, head_item, status,
                   entry_count, output ready);
endinterface

// ===== rtl/core/spq_ram.sv =====
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/spq_seq.sv =====
// ----------------------------------------------------------------------------
// spq_seq
// Sequencer with one shared priority comparator and one ring address adder;
// walks the sorted ring held in memory one entry at a time.
// ----------------------------------------------------------------------------
module spq_seq (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               start_mode,
   input  spq_pkg::entry_type                 start_entry,
   output logic                               idle,
   output logic                               done,
   output spq_pkg::result_type                result,
   output spq_pkg::mem_req_type               mem_req,
   input  spq_pkg::entry_type                 mem_rd_data
);

   spq_pkg::state_type                     state_ff, state_in;
   logic [spq_pkg::IDX_W-1:0]              head_ff, head_in;
   logic [spq_pkg::CNT_W-1:0]              count_ff, count_in;
   logic [spq_pkg::IDX_W-1:0]              pos_ff, pos_in;
   spq_pkg::entry_type                     new_ff, new_in;
   spq_pkg::entry_type                     rem_ff, rem_in;
   spq_pkg::status_type                    status_ff, status_in;

   logic [spq_pkg::IDX_W-1:0]              lidx;
   logic [spq_pkg::IDX_W:0]                ring_sum;
   logic [spq_pkg::IDX_W-1:0]              phys;
   logic                                   stored_lower;
   logic [spq_pkg::CNT_W+spq_pkg::COUNT_OUT_W-1:0] count_ext;

   // shared ring adder: logical slot to physical address
   assign ring_sum = {1'b0, head_ff} + {1'b0, lidx};
   always_comb begin
      if (ring_sum >= spq_pkg::CAP_EXT) begin
         phys = spq_pkg::IDX_W'(ring_sum - spq_pkg::CAP_EXT);
      end else begin
         phys = ring_sum[spq_pkg::IDX_W-1:0];
      end
   end

   // shared comparator: stored priority strictly below the new one
   assign stored_lower = (mem_rd_data.prio < new_ff.prio);

   assign count_ext = {{spq_pkg::COUNT_OUT_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spq_pkg::ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      new_ff    <= new_in;
      rem_ff    <= rem_in;
      status_ff <= status_in;
   end

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      new_in    = new_ff;
      rem_in    = rem_ff;
      status_in = status_ff;
      lidx      = '0;
      mem_req   = '{wr_en: 1'b0, rd_en: 1'b0, addr: '0, wr_data: new_ff};
      idle      = 1'b0;
      done      = 1'b0;

      unique case (state_ff)
         spq_pkg::ST_IDLE: begin
            idle = 1'b1;
            if (start) begin
               new_in    = start_entry;
               rem_in    = '0;
               status_in = spq_pkg::STATUS_OK;
               pos_in    = count_ff[spq_pkg::IDX_W-1:0];
               if (start_mode == spq_pkg::MODE_INSERT) begin
                  if (count_ff == spq_pkg::CAP_CNT) begin
                     status_in = spq_pkg::STATUS_FULL;
                     state_in  = spq_pkg::ST_HEAD_RD;
                  end else begin
                     state_in  = spq_pkg::ST_INS_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = spq_pkg::STATUS_UNDERFLOW;
                     state_in  = spq_pkg::ST_HEAD_RD;
                  end else begin
                     state_in  = spq_pkg::ST_REM_RD;
                  end
               end
            end
         end
         spq_pkg::ST_INS_RD: begin
            if (pos_ff == '0) begin
               // reached the head: new entry lands in slot 0
               lidx           = '0;
               mem_req.wr_en  = 1'b1;
               mem_req.addr   = phys;
               count_in       = count_ff + 1'b1;
               state_in       = spq_pkg::ST_HEAD_RD;
            end else begin
               lidx          = pos_ff - 1'b1;
               mem_req.rd_en = 1'b1;
               mem_req.addr  = phys;
               state_in      = spq_pkg::ST_INS_CMP;
            end
         end
         spq_pkg::ST_INS_CMP: begin
            lidx          = pos_ff;
            mem_req.wr_en = 1'b1;
            mem_req.addr  = phys;
            if (stored_lower) begin
               // move the lower entry one slot toward the tail
               mem_req.wr_data = mem_rd_data;
               pos_in          = pos_ff - 1'b1;
               state_in        = spq_pkg::ST_INS_RD;
            end else begin
               count_in = count_ff + 1'b1;
               state_in = spq_pkg::ST_HEAD_RD;
            end
         end
         spq_pkg::ST_REM_RD: begin
            lidx          = '0;
            mem_req.rd_en = 1'b1;
            mem_req.addr  = phys;
            state_in      = spq_pkg::ST_REM_CAP;
         end
         spq_pkg::ST_REM_CAP: begin
            rem_in   = mem_rd_data;
            head_in  = (head_ff == spq_pkg::LAST_IDX) ? '0 : head_ff + 1'b1;
            count_in = count_ff - 1'b1;
            state_in = spq_pkg::ST_HEAD_RD;
         end
         spq_pkg::ST_HEAD_RD: begin
            lidx          = '0;
            mem_req.rd_en = 1'b1;
            mem_req.addr  = phys;
            state_in      = spq_pkg::ST_HEAD_CAP;
         end
         spq_pkg::ST_HEAD_CAP: begin
            done     = 1'b1;
            state_in = spq_pkg::ST_IDLE;
         end
         default: begin
            state_in = spq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      result.removed_item     = rem_ff.item;
      result.removed_priority = rem_ff.prio;
      result.head_item        = (count_ff != '0) ? mem_rd_data.item : '1;
      result.status           = status_ff;
      result.entry_count      = count_ext[spq_pkg::COUNT_OUT_W-1:0];
   end

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue of up to spq_pkg::CAPACITY (item, priority) entries kept
// sorted by descending priority in a ring buffer memory.
// ----------------------------------------------------------------------------
// One request beat is taken at a time and gives exactly one response beat.
// Entries live in one RAM as a ring; the head pointer moves on a remove, so a
// remove moves no entries. An insert walks from the tail toward the head
// through the shared priority comparator, in two steps per entry that must
// move back (read, then compare and write); the one address shared by the
// RAM read and write ports sets that split. A dropped insert on a full queue
// or a remove on an empty queue goes straight to the head read.
// Equal priorities keep arrival order. The next request beat is taken once
// the sequencer is idle and the response register is free or being drained.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_bus,
   spq_rsp_if.source rsp_bus
);

   // sequencer handshake
   logic                   seq_idle;
   logic                   seq_done;
   logic                   req_fire;
   spq_pkg::entry_type     req_entry;
   spq_pkg::result_type    seq_result;

   // memory access
   spq_pkg::mem_req_type   mem_req;
   spq_pkg::entry_type     mem_rd_data;
   logic [spq_pkg::ENTRY_W-1:0] mem_rd_raw;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   spq_pkg::result_type    rsp_data_ff, rsp_data_in;

   // take a beat only out of reset, when idle and the response slot frees up
   assign req_bus.ready = !reset && seq_idle && (!rsp_valid_ff || rsp_bus.ready);
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign req_entry.item = req_bus.item_value;
   assign req_entry.prio = req_bus.item_priority;

   spq_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (req_fire),
      .start_mode  (req_bus.mode),
      .start_entry (req_entry),
      .idle        (seq_idle),
      .done        (seq_done),
      .result      (seq_result),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data)
   );

   // sorted ring storage, one entry per word
   spq_ram #(
      .WIDTH (spq_pkg::ENTRY_W),
      .DEPTH (spq_pkg::CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.addr),
      .rd_data (mem_rd_raw)
   );

   assign mem_rd_data = spq_pkg::entry_type'(mem_rd_raw);

   // response beat register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (seq_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.removed_item     = rsp_data_ff.removed_item;
   assign rsp_bus.removed_priority = rsp_data_ff.removed_priority;
   assign rsp_bus.head_item        = rsp_data_ff.head_item;
   assign rsp_bus.status           = rsp_data_ff.status;
   assign rsp_bus.entry_count      = rsp_data_ff.entry_count;

`ifndef NO_ASSERTIONS
   // an accepted beat keeps the block busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_bus.ready)
      else $error("request taken while previous beat still in work");

   // failed operations never report a removed entry
   a_no_removed_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.status != spq_pkg::STATUS_OK)) |->
         (rsp_bus.removed_item == '0 && rsp_bus.removed_priority == '0))
      else $error("removed entry reported on failed operation");

   // an underflow leaves the queue empty
   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.status == spq_pkg::STATUS_UNDERFLOW)) |->
         (rsp_bus.entry_count == '0 && rsp_bus.head_item == '1))
      else $error("underflow response with nonempty queue");

   // a finished operation never lands on an unread response
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      seq_done |-> (!rsp_valid_ff || rsp_bus.ready))
      else $error("response register overwritten");
`endif

endmodule

// ===== verif/tb_sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Self-checking bench for the sorted priority queue. A short table of
// directed beats covers the empty corner, extreme words and priority ties.
// Random fill-to-full, drain and mixed runs follow under several idling phases.
// Every response beat is checked field by field against the model or a table row.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;

   // extreme signed words used by the table and the random mix
   localparam logic signed [spq_pkg::VALUE_W-1:0] WORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [spq_pkg::VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [spq_pkg::VALUE_W-1:0] WORD_NEG = -32'sd1;

   // items per idling phase of the random part
   localparam int PHASE_ITEMS = 310;
   // tail wait, sized past the longest insert
   localparam int TAIL_CYCLES = 2 * spq_pkg::CAPACITY + 12;

   // one row of the directed table; want is used only where typed is set
   typedef struct packed {
      logic                               mode;
      logic signed [spq_pkg::VALUE_W-1:0] value;
      logic signed [spq_pkg::VALUE_W-1:0] prio;
      logic                               typed;
      spq_pkg::result_type                want;
   } directed_row;

   localparam spq_pkg::result_type EMPTY_UNDERFLOW = '{32'sd0, 32'sd0, WORD_NEG,
                                                      spq_pkg::STATUS_UNDERFLOW, 7'd0};

   localparam directed_row DIRECTED_ROWS [23] = '{
      // remove on an empty queue
      '{spq_pkg::MODE_REMOVE, 32'sd0, 32'sd0, 1'b1, EMPTY_UNDERFLOW},
      // extreme item and priority words, highest priority goes to the head
      '{spq_pkg::MODE_INSERT, WORD_MAX, WORD_MIN, 1'b1,
        '{32'sd0, 32'sd0, WORD_MAX, spq_pkg::STATUS_OK, 7'd1}},
      '{spq_pkg::MODE_INSERT, WORD_MIN, WORD_MAX, 1'b1,
        '{32'sd0, 32'sd0, WORD_MIN, spq_pkg::STATUS_OK, 7'd2}},
      // ties land behind older entries of the same priority
      '{spq_pkg::MODE_INSERT, 32'sd0, 32'sd0, 1'b0, '0},
      '{spq_pkg::MODE_INSERT, WORD_NEG, 32'sd0, 1'b0, '0},
      '{spq_pkg::MODE_INSERT, 32'sd5, WORD_NEG, 1'b0, '0},
      '{spq_pkg::MODE_INSERT, 32'sd7, WORD_MAX, 1'b0, '0},
      // drain in priority order, extremes first and last
      '{spq_pkg::MODE_REMOVE, 32'sd0, 32'sd0, 1'b1,
        '{WORD_MIN, WORD_MAX, 32'sd7, spq_pkg::STATUS_OK, 7'd5}},
      '{spq_pkg::MODE_REMOVE, 32'sd0, 32'sd0, 1'b0, '0},
      '{spq_pkg::MODE_REMOVE, 32'sd0, 32'sd0, 1'b0, '0},
      '{spq_pkg::MODE_REMOVE, 32'sd0, 32'sd0, 1'b0, '0},
      '{spq_pkg::MODE_REMOVE, 32'sd0, 32'sd0, 1'b0, '0},
      '{spq_pkg::MODE_REMOVE, 32'sd0, 32'sd0, 1'b1,
        '{WORD_MAX, WORD_MIN, WORD_NEG, spq_pkg::STATUS_OK, 7'd0}},
      // remove fields are don't-care, drive them all ones
      '{spq_pkg::MODE_REMOVE, WORD_NEG, WORD_NEG, 1'b1, EMPTY_UNDERFLOW},
      // alternating bit patterns, a negative priority and a tie
      '{spq_pkg::MODE_INSERT, 32'shaaaa_aaaa, 32'sh5555_5555, 1'b0, '0},
      '{spq_pkg::MODE_INSERT, 32'sh5555_5555, 32'shaaaa_aaaa, 1'b0, '0},
      '{spq_pkg::MODE_INSERT, 32'sd1, 32'sh5555_5555, 1'b0, '0},
      '{spq_pkg::MODE_INSERT, 32'sd2, 32'sd1, 1'b0, '0},
      '{spq_pkg::MODE_REMOVE, 32'shffff_0000, 32'sh0000_ffff, 1'b0, '0},
      '{spq_pkg::MODE_REMOVE, 32'sd0, 32'sd0, 1'b0, '0},
      '{spq_pkg::MODE_REMOVE, 32'sd0, 32'sd0, 1'b0, '0},
      '{spq_pkg::MODE_REMOVE, 32'sd0, 32'sd0, 1'b0, '0},
      '{spq_pkg::MODE_REMOVE, 32'sd0, 32'sd0, 1'b1, EMPTY_UNDERFLOW}
   };

   logic clock = 1'b0;
   logic reset;

   spq_req_if req_bus ();
   spq_rsp_if rsp_bus ();

   sorted_priority_queue dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   // model of the queue contents, slot 0 is the head
   logic signed [spq_pkg::VALUE_W-1:0] held_item [spq_pkg::CAPACITY];
   logic signed [spq_pkg::VALUE_W-1:0] held_prio [spq_pkg::CAPACITY];
   int                                 held_count = 0;

   // responses owed by the block, oldest first
   spq_pkg::result_type awaited_rsp [$];

   int fail_count    = 0;
   int items_sent    = 0;
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;

   // apply one request to the model and return the response it should give
   function automatic spq_pkg::result_type next_queue_rsp(
         input logic                               mode,
         input logic signed [spq_pkg::VALUE_W-1:0] value,
         input logic signed [spq_pkg::VALUE_W-1:0] prio);
      spq_pkg::result_type r;
      int                  slot;
      r = '0;
      r.status = spq_pkg::STATUS_OK;
      if (mode == spq_pkg::MODE_INSERT) begin
         if (held_count >= spq_pkg::CAPACITY) begin
            // full, the entry is dropped
            r.status = spq_pkg::STATUS_FULL;
         end else begin
            // step past every entry of greater or equal priority
            slot = 0;
            while (slot < held_count && held_prio[slot] >= prio) slot++;
            for (int k = held_count; k > slot; k--) begin
               held_item[k] = held_item[k-1];
               held_prio[k] = held_prio[k-1];
            end
            held_item[slot] = value;
            held_prio[slot] = prio;
            held_count++;
         end
      end else begin
         if (held_count == 0) begin
            r.status = spq_pkg::STATUS_UNDERFLOW;
         end else begin
            r.removed_item     = held_item[0];
            r.removed_priority = held_prio[0];
            for (int k = 1; k < held_count; k++) begin
               held_item[k-1] = held_item[k];
               held_prio[k-1] = held_prio[k];
            end
            held_count--;
         end
      end
      r.head_item   = (held_count != 0) ? held_item[0] : WORD_NEG;
      r.entry_count = spq_pkg::COUNT_OUT_W'(held_count);
      return r;
   endfunction

   function automatic logic signed [spq_pkg::VALUE_W-1:0] extreme_word();
      case ($urandom_range(0, 4))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return WORD_NEG;
         3: return 32'sd0;
         default: return 32'sd1;
      endcase
   endfunction

   // narrow band for ties, some extremes, the rest full range
   function automatic logic signed [spq_pkg::VALUE_W-1:0] pick_prio();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 4) return $signed(spq_pkg::VALUE_W'($urandom_range(0, 15))) - 32'sd8;
      if (roll < 6) return extreme_word();
      return $signed($urandom());
   endfunction

   function automatic logic signed [spq_pkg::VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 9) == 0) return extreme_word();
      return $signed($urandom());
   endfunction

   // present one request beat, wait for it to be taken, then book the
   // response; valid stays high into the next beat unless a gap is rolled
   task automatic send_beat(input logic                               mode,
                            input logic signed [spq_pkg::VALUE_W-1:0] value,
                            input logic signed [spq_pkg::VALUE_W-1:0] prio,
                            input logic                               typed,
                            input spq_pkg::result_type                want);
      spq_pkg::result_type predicted;
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < req_idle_pct) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.mode          <= mode;
      req_bus.item_value    <= value;
      req_bus.item_priority <= prio;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // beat taken at this edge
      predicted = next_queue_rsp(mode, value, prio);
      awaited_rsp.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   task automatic random_beat(input int insert_pct);
      if ($urandom_range(0, 99) < insert_pct)
         send_beat(spq_pkg::MODE_INSERT, pick_value(), pick_prio(), 1'b0, '0);
      else
         send_beat(spq_pkg::MODE_REMOVE, pick_value(), pick_prio(), 1'b0, '0);
   endtask

   // mostly inserts until full, then a few dropped inserts
   task automatic fill_run();
      int extra;
      extra = $urandom_range(1, 3);
      while (extra > 0) begin
         if (held_count == spq_pkg::CAPACITY) extra--;
         random_beat(90);
      end
   endtask

   // mostly removes until empty, then a few underflows
   task automatic drain_run();
      int extra;
      extra = $urandom_range(1, 3);
      while (extra > 0) begin
         if (held_count == 0) extra--;
         random_beat(10);
      end
   endtask

   task automatic check_field(input string                              name,
                              input logic signed [spq_pkg::VALUE_W-1:0] want,
                              input logic signed [spq_pkg::VALUE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // response side: check every beat against the oldest booked response
   always @(posedge clock) begin : rsp_watch
      spq_pkg::result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_rsp.size() == 0) begin
               $error("response beat with none outstanding");
               fail_count++;
            end else begin
               want = awaited_rsp.pop_front();
               check_field("removed_item", want.removed_item, rsp_bus.removed_item);
               check_field("removed_priority", want.removed_priority,
                           rsp_bus.removed_priority);
               check_field("head_item", want.head_item, rsp_bus.head_item);
               check_field("status", want.status, rsp_bus.status);
               check_field("entry_count", want.entry_count, rsp_bus.entry_count);
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // stimulus
   initial begin : stimulus
      int target;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.mode          = spq_pkg::MODE_INSERT;
      req_bus.item_value    = '0;
      req_bus.item_priority = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table, no idling
      foreach (DIRECTED_ROWS[i])
         send_beat(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].value,
                   DIRECTED_ROWS[i].prio, DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].want);

      // random runs under each idling phase: none, sender, receiver, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 80; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 80; end
            default: begin req_idle_pct = 19; rsp_stall_pct = 19; end
         endcase
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            case ($urandom_range(0, 3))
               0, 1: fill_run();
               2: drain_run();
               default: repeat ($urandom_range(10, 40)) random_beat(50);
            endcase
         end
      end

      req_bus.valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      // catch any stray beat after the last one owed
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("sorted_priority_queue test passed");
      else
         $display("sorted_priority_queue test failed");
      $finish;
   end

   // hard stop if the handshakes hang
   initial begin : watchdog
      #20_000_000;
      $display("sorted_priority_queue test failed");
      $finish;
   end

endmodule
